[rtl/assert_macros.svh]
// assertion macros used by the navigator top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset is released
`define MFFN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define MFFN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/mffn_pkg.sv]
// types, constants and grid helpers of the maze flood fill navigator
package mffn_pkg;

  localparam int unsigned MazeSide      = 16;
  localparam int unsigned StackDepthDef = 512;
  localparam int unsigned PopBudgetW    = 20;

  localparam logic [4:0] SideW5    = 5'(MazeSide);
  localparam logic [3:0] CentreHi  = 4'(MazeSide / 2);
  localparam logic [3:0] CentreLo  = 4'(MazeSide / 2 - 1);
  localparam logic [7:0] CostStart = 8'(2 * MazeSide);

  typedef enum logic [2:0] {
    MOVE_FWD   = 3'd0,
    MOVE_LEFT  = 3'd1,
    MOVE_RIGHT = 3'd2,
    MOVE_BACK  = 3'd3,
    MOVE_NONE  = 3'd4
  } move_e;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_e;

  // neighbour inside the grid
  function automatic logic step_ok(logic [3:0] x, logic [3:0] y, logic [1:0] d);
    logic ok;
    ok = 1'b0;
    unique case (dir_e'(d))
      DIR_N: ok = ({1'b0, y} + 5'd1) < SideW5;
      DIR_E: ok = ({1'b0, x} + 5'd1) < SideW5;
      DIR_S: ok = (y != 4'd0);
      DIR_W: ok = (x != 4'd0);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // cell index of the neighbour, x in the upper nibble
  function automatic logic [7:0] nbr_idx(logic [3:0] x, logic [3:0] y, logic [1:0] d);
    logic [7:0] idx;
    idx = {x, y};
    unique case (dir_e'(d))
      DIR_N: idx = {x, y + 4'd1};
      DIR_E: idx = {x + 4'd1, y};
      DIR_S: idx = {x, y - 4'd1};
      DIR_W: idx = {x - 4'd1, y};
      default: idx = {x, y};
    endcase
    return idx;
  endfunction

  function automatic logic is_goal(logic [3:0] x, logic [3:0] y, logic mode);
    logic g;
    if (mode) begin
      g = (x == 4'd0) && (y == 4'd0);
    end else begin
      g = ((x == CentreLo) || (x == CentreHi)) && ((y == CentreLo) || (y == CentreHi));
    end
    return g;
  endfunction

  // heading offset of front, left, right, back
  function automatic logic [1:0] rel_turn(logic [1:0] k);
    logic [1:0] t;
    unique case (k)
      2'd0: t = 2'd0;
      2'd1: t = 2'd3;
      2'd2: t = 2'd1;
      default: t = 2'd2;
    endcase
    return t;
  endfunction

  // push order of the reflood, explored cells and unexplored cells
  function automatic logic [1:0] push_dir(logic known, logic [1:0] j);
    logic [1:0] d;
    if (known) begin
      unique case (j)
        2'd0: d = DIR_N;
        2'd1: d = DIR_S;
        2'd2: d = DIR_W;
        default: d = DIR_E;
      endcase
    end else begin
      unique case (j)
        2'd0: d = DIR_E;
        2'd1: d = DIR_W;
        2'd2: d = DIR_N;
        default: d = DIR_S;
      endcase
    end
    return d;
  endfunction

  function automatic logic [7:0] centre_cost(logic [7:0] idx);
    logic [3:0] x, y, dx, dy;
    x  = idx[7:4];
    y  = idx[3:0];
    dx = (x < CentreHi) ? (CentreLo - x) : (x - CentreHi);
    dy = (y < CentreHi) ? (CentreLo - y) : (y - CentreHi);
    return {4'd0, dx} + {4'd0, dy};
  endfunction

  function automatic logic [7:0] start_cost(logic [7:0] idx);
    return {4'd0, idx[7:4]} + {4'd0, idx[3:0]};
  endfunction

endpackage

[rtl/maze_flood_fill_navigator_top.sv]
// maze flood fill navigator: wall memory, cost memory of both modes, reflood stack, sequencer
//
// usage
// - input channel in_valid_i / in_ready_o: one transfer is one arrival at a cell with the
//   three wall sensor bits; exactly one result leaves on out_valid_o / out_ready_i
// - configuration channel cfg_valid_i / cfg_ready_o: writes search_mode; the user must
//   write it only while idle, the block does not enforce this; cfg_ready_o is always high
// - one item at a time: without reflood the result takes five cost reads from the single
//   cost memory port, and the next transfer in is taken once the sequencer is back in
//   idle; a goal cell skips the cost reads
// - a reflood: each stack pop that rewrites a cost takes a stack read, wall read, five
//   cost reads and four push slots, one that finds it unchanged no push slots, a goal
//   cell pop only the stack read; then the empty stack check and the second choice
// - after reset a clearing pass loads the reset costs of both modes and clears the wall
//   and arrival memories; in_ready_o stays low during it
// - the result sits in an output register; a new item is taken while it waits, and a
//   finished item holds in its last state while the receiver stalls
// - reset puts the robot at cell 0,0 facing north in centre seeking mode
module maze_flood_fill_navigator_top #(
  parameter int unsigned STACK_DEPTH = mffn_pkg::StackDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_search_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       wall_ahead_i,
  input  logic       wall_on_left_i,
  input  logic       wall_on_right_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] move_o,
  output logic       at_goal_o,
  output logic [3:0] pos_x_o,
  output logic [3:0] pos_y_o,
  output logic [1:0] heading_o,
  output logic       reflooded_o,
  output logic       stack_overflow_o
);
  import mffn_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned TopW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AdrW = $clog2(STACK_DEPTH);

  typedef enum logic [12:0] {
    S_INIT    = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_EXPL    = 13'b0000000000100,
    S_CH_RD   = 13'b0000000001000,
    S_CH_EV   = 13'b0000000010000,
    S_RF_POP  = 13'b0000000100000,
    S_RF_IDX  = 13'b0000001000000,
    S_RF_CELL = 13'b0000010000000,
    S_RF_RD   = 13'b0000100000000,
    S_RF_EV   = 13'b0001000000000,
    S_RF_PUSH = 13'b0010000000000,
    S_MOVE    = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0] x_q, x_d, y_q, y_d;
  logic [1:0] hd_q, hd_d;
  logic       mode_q, mode_d;
  logic [2:0] blk_q, blk_d;
  logic [8:0] from_q, from_d;
  logic [2:0] ck_q, ck_d;
  logic       cand_ok_q, cand_ok_d;
  logic [7:0] best_q, best_d;
  move_e      dir_q, dir_d;
  logic       flooded_q, flooded_d;
  logic       ovf_q, ovf_d;
  logic       goal_q, goal_d;
  logic [TopW-1:0]     top_q, top_d;
  logic [PopBudgetW:0] pops_q, pops_d;
  logic [7:0] ridx_q, ridx_d;
  logic       rexpl_q, rexpl_d;
  logic [3:0] rwalls_q, rwalls_d;
  logic [2:0] rd_q, rd_d;
  logic [7:0] rm_q, rm_d;
  logic [3:0] ropen_q, ropen_d;
  logic [1:0] pj_q, pj_d;
  logic [8:0] init_q, init_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] out_move_q, out_move_d;
  logic       out_goal_q, out_goal_d;
  logic [3:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [1:0] out_hd_q, out_hd_d;
  logic       out_refl_q, out_refl_d;
  logic       out_ovf_q, out_ovf_d;

  // memories, one write and one registered read port each
  logic [7:0] cost_mem [512];
  logic [4:0] cell_mem [256];
  logic [8:0] from_mem [256];
  logic [7:0] stack_mem [STACK_DEPTH];

  logic       cost_we, cell_we, from_we, stack_we;
  logic [8:0] cost_waddr, cost_raddr;
  logic [7:0] cost_wdata, cost_rd_q;
  logic [7:0] cell_waddr, cell_raddr, from_waddr, stack_wdata, stack_rd_q;
  logic [4:0] cell_wdata, cell_rd_q;
  logic [8:0] from_wdata, from_rd_q;
  logic [AdrW-1:0] stack_waddr, stack_raddr;

  always_ff @(posedge clk_i) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    cost_rd_q <= cost_mem[cost_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rd_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (from_we) begin
      from_mem[from_waddr] <= from_wdata;
    end
    from_rd_q <= from_mem[{x_q, y_q}];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rd_q <= stack_mem[stack_raddr];
  end

  // address helpers
  logic [7:0]      here;
  logic [1:0]      ch_dir;
  logic [7:0]      ch_addr, rf_addr;
  logic            ch_ok;
  logic [3:0]      rcx, rcy;
  logic [TopW-1:0] top_m1;
  logic [8:0]      rm_sum;
  logic [7:0]      nv;
  logic [1:0]      pdir;
  logic [3:0]      wnew;
  logic [1:0]      mv_hd;

  assign here   = {x_q, y_q};
  assign rcx    = ridx_q[7:4];
  assign rcy    = ridx_q[3:0];
  assign top_m1 = top_q - TopW'(1);
  assign ch_dir = hd_q + rel_turn(ck_q[1:0]);
  assign rm_sum = {1'b0, rm_q} + 9'd1;
  assign nv     = rm_sum[8] ? 8'hFF : rm_sum[7:0];
  assign pdir   = push_dir(rexpl_q, pj_q);
  assign mv_hd  = hd_q + rel_turn(dir_q[1:0]);

  always_comb begin
    ch_ok   = 1'b0;
    ch_addr = here;
    unique case (ck_q)
      3'd0, 3'd1, 3'd2: begin
        ch_ok   = !blk_q[ck_q[1:0]] && step_ok(x_q, y_q, ch_dir);
        ch_addr = nbr_idx(x_q, y_q, ch_dir);
      end
      3'd3: begin
        ch_ok   = from_q[8];
        ch_addr = from_q[7:0];
      end
      default: begin
        ch_ok   = 1'b1;
        ch_addr = here;
      end
    endcase
  end

  assign rf_addr = rd_q[2] ? ridx_q : nbr_idx(rcx, rcy, rd_q[1:0]);

  // walls of a first visit: the wall behind keeps its reset value
  always_comb begin
    wnew = (here == 8'd0) ? 4'b0100 : 4'b0000;
    wnew[hd_q]        = blk_q[0];
    wnew[hd_q + 2'd3] = blk_q[1];
    wnew[hd_q + 2'd1] = blk_q[2];
  end

  assign cost_raddr  = {mode_q, (state_q == S_RF_RD) ? rf_addr : ch_addr};
  assign cell_raddr  = (state_q == S_RF_IDX) ? stack_rd_q : here;
  assign stack_raddr = top_m1[AdrW-1:0];

  always_comb begin
    state_d   = state_q;
    x_d = x_q; y_d = y_q; hd_d = hd_q;
    mode_d    = mode_q;
    blk_d     = blk_q;
    from_d    = from_q;
    ck_d      = ck_q;
    cand_ok_d = cand_ok_q;
    best_d    = best_q;
    dir_d     = dir_q;
    flooded_d = flooded_q;
    ovf_d     = ovf_q;
    goal_d    = goal_q;
    top_d     = top_q;
    pops_d    = pops_q;
    ridx_d    = ridx_q;
    rexpl_d   = rexpl_q;
    rwalls_d  = rwalls_q;
    rd_d      = rd_q;
    rm_d      = rm_q;
    ropen_d   = ropen_q;
    pj_d      = pj_q;
    init_d    = init_q;
    out_valid_d = out_valid_q;
    out_move_d  = out_move_q;
    out_goal_d  = out_goal_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_hd_d    = out_hd_q;
    out_refl_d  = out_refl_q;
    out_ovf_d   = out_ovf_q;

    cost_we = 1'b0; cost_waddr = {mode_q, ridx_q}; cost_wdata = nv;
    cell_we = 1'b0; cell_waddr = here; cell_wdata = {1'b1, wnew};
    from_we = 1'b0; from_waddr = nbr_idx(x_q, y_q, mv_hd); from_wdata = {1'b1, here};
    stack_we = 1'b0; stack_waddr = top_q[AdrW-1:0];
    stack_wdata = nbr_idx(rcx, rcy, pdir);

    if (cfg_valid_i) begin
      mode_d = cfg_search_mode_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        // clearing pass: reset costs of both modes, empty walls and arrivals
        cost_we    = 1'b1;
        cost_waddr = init_q;
        cost_wdata = init_q[8] ? start_cost(init_q[7:0]) : centre_cost(init_q[7:0]);
        cell_we    = 1'b1;
        cell_waddr = init_q[7:0];
        cell_wdata = 5'd0;
        from_we    = 1'b1;
        from_waddr = init_q[7:0];
        from_wdata = 9'd0;
        init_d     = init_q + 9'd1;
        if (init_q == 9'h1FF) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          blk_d     = {wall_on_right_i, wall_on_left_i, wall_ahead_i};
          flooded_d = 1'b0;
          ovf_d     = 1'b0;
          goal_d    = 1'b0;
          state_d   = S_EXPL;
        end
      end
      S_EXPL: begin
        if (!cell_rd_q[4]) begin
          cell_we = 1'b1;
        end
        from_d = from_rd_q;
        best_d = CostStart;
        dir_d  = MOVE_NONE;
        ck_d   = 3'd0;
        if (is_goal(x_q, y_q, mode_q)) begin
          goal_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_CH_RD;
        end
      end
      S_CH_RD: begin
        cand_ok_d = ch_ok;
        state_d   = S_CH_EV;
      end
      S_CH_EV: begin
        if (ck_q != 3'd4) begin
          if (cand_ok_q && (cost_rd_q < best_q)) begin
            best_d = cost_rd_q;
            dir_d  = move_e'(ck_q);
          end
          ck_d    = ck_q + 3'd1;
          state_d = S_CH_RD;
        end else if (!flooded_q && ({1'b0, cost_rd_q} != ({1'b0, best_q} + 9'd1))) begin
          // cost inconsistent: reflood starting from this cell
          stack_we    = 1'b1;
          stack_waddr = '0;
          stack_wdata = here;
          top_d       = TopW'(1);
          pops_d      = '0;
          flooded_d   = 1'b1;
          state_d     = S_RF_POP;
        end else begin
          state_d = S_MOVE;
        end
      end
      S_RF_POP: begin
        if ((top_q == '0) || pops_q[PopBudgetW]) begin
          top_d   = '0;
          best_d  = CostStart;
          dir_d   = MOVE_NONE;
          ck_d    = 3'd0;
          state_d = S_CH_RD;
        end else begin
          top_d   = top_m1;
          pops_d  = pops_q + 1'b1;
          state_d = S_RF_IDX;
        end
      end
      S_RF_IDX: begin
        ridx_d = stack_rd_q;
        if (({1'b0, stack_rd_q[7:4]} >= SideW5) || ({1'b0, stack_rd_q[3:0]} >= SideW5) ||
            is_goal(stack_rd_q[7:4], stack_rd_q[3:0], mode_q)) begin
          state_d = S_RF_POP;
        end else begin
          state_d = S_RF_CELL;
        end
      end
      S_RF_CELL: begin
        rexpl_d  = cell_rd_q[4];
        rwalls_d = cell_rd_q[3:0];
        rd_d     = 3'd0;
        rm_d     = CostStart;
        ropen_d  = 4'd0;
        state_d  = S_RF_RD;
      end
      S_RF_RD: begin
        state_d = S_RF_EV;
      end
      S_RF_EV: begin
        if (!rd_q[2]) begin
          // unexplored cells count as open on every side
          if (step_ok(rcx, rcy, rd_q[1:0]) && (!rexpl_q || !rwalls_q[rd_q[1:0]])) begin
            ropen_d[rd_q[1:0]] = 1'b1;
            if (cost_rd_q < rm_q) begin
              rm_d = cost_rd_q;
            end
          end
          rd_d    = rd_q + 3'd1;
          state_d = S_RF_RD;
        end else if (cost_rd_q == nv) begin
          state_d = S_RF_POP;
        end else begin
          cost_we = 1'b1;
          pj_d    = 2'd0;
          state_d = S_RF_PUSH;
        end
      end
      S_RF_PUSH: begin
        if (ropen_q[pdir]) begin
          if (top_q >= TopW'(STACK_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            stack_we = 1'b1;
            top_d    = top_q + TopW'(1);
          end
        end
        pj_d = pj_q + 2'd1;
        if (pj_q == 2'd3) begin
          state_d = S_RF_POP;
        end
      end
      S_MOVE: begin
        if (dir_q != MOVE_NONE) begin
          hd_d = mv_hd;
          if (step_ok(x_q, y_q, mv_hd)) begin
            x_d     = from_waddr[7:4];
            y_d     = from_waddr[3:0];
            from_we = 1'b1;
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_move_d  = dir_q;
          out_goal_d  = goal_q;
          out_x_d     = x_q;
          out_y_d     = y_q;
          out_hd_d    = hd_q;
          out_refl_d  = flooded_q;
          out_ovf_d   = ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      x_q <= '0; y_q <= '0; hd_q <= '0;
      mode_q    <= 1'b0;
      blk_q     <= '0;
      from_q    <= '0;
      ck_q      <= '0;
      cand_ok_q <= 1'b0;
      best_q    <= '0;
      dir_q     <= MOVE_NONE;
      flooded_q <= 1'b0;
      ovf_q     <= 1'b0;
      goal_q    <= 1'b0;
      top_q     <= '0;
      pops_q    <= '0;
      ridx_q    <= '0;
      rexpl_q   <= 1'b0;
      rwalls_q  <= '0;
      rd_q      <= '0;
      rm_q      <= '0;
      ropen_q   <= '0;
      pj_q      <= '0;
      init_q    <= '0;
      out_valid_q <= 1'b0;
      out_move_q  <= '0;
      out_goal_q  <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_hd_q    <= '0;
      out_refl_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      x_q <= x_d; y_q <= y_d; hd_q <= hd_d;
      mode_q    <= mode_d;
      blk_q     <= blk_d;
      from_q    <= from_d;
      ck_q      <= ck_d;
      cand_ok_q <= cand_ok_d;
      best_q    <= best_d;
      dir_q     <= dir_d;
      flooded_q <= flooded_d;
      ovf_q     <= ovf_d;
      goal_q    <= goal_d;
      top_q     <= top_d;
      pops_q    <= pops_d;
      ridx_q    <= ridx_d;
      rexpl_q   <= rexpl_d;
      rwalls_q  <= rwalls_d;
      rd_q      <= rd_d;
      rm_q      <= rm_d;
      ropen_q   <= ropen_d;
      pj_q      <= pj_d;
      init_q    <= init_d;
      out_valid_q <= out_valid_d;
      out_move_q  <= out_move_d;
      out_goal_q  <= out_goal_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_hd_q    <= out_hd_d;
      out_refl_q  <= out_refl_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign move_o           = out_move_q;
  assign at_goal_o        = out_goal_q;
  assign pos_x_o          = out_x_q;
  assign pos_y_o          = out_y_q;
  assign heading_o        = out_hd_q;
  assign reflooded_o      = out_refl_q;
  assign stack_overflow_o = out_ovf_q;

  `MFFN_ASSERT(a_top_bound, top_q <= TopW'(STACK_DEPTH), "stack top beyond depth")
  `MFFN_ASSERT(a_goal_stays, (out_valid_o && at_goal_o) |-> (move_o == MOVE_NONE), "goal with move")
  `MFFN_ASSERT(a_ovf_flood, (out_valid_o && stack_overflow_o) |-> reflooded_o, "overflow without reflood")
  `MFFN_ASSERT_ALWAYS(a_take_expl, (rst_ni && in_valid_i && in_ready_o) |=> (state_q == S_EXPL), "transfer not started")

endmodule

[tb/sv/maze_flood_fill_navigator_top_test.sv]
// testbench of the maze flood fill navigator: directed table, random walks, scoreboard
`timescale 1ns / 100ps

module maze_flood_fill_navigator_top_test;
  import mffn_pkg::*;

  typedef struct packed {
    logic [2:0] move;
    logic       at_goal;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [1:0] heading;
    logic       reflooded;
    logic       stack_overflow;
  } nav_result_t;

  typedef struct packed {
    logic        mode;
    logic        wall_a;
    logic        wall_l;
    logic        wall_r;
    logic        typed;
    nav_result_t want;
  } sense_row_t;

  localparam int unsigned Side       = 16;
  localparam int unsigned StackCells = 512;
  localparam int unsigned PopLimit   = 1 << 20;
  // covers a full pop budget of the reflood, with a wide margin
  localparam int unsigned WdLimit    = 80 * PopLimit;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandPerPh  = 29;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_search_mode_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic wall_ahead_i = 1'b0;
  logic wall_on_left_i = 1'b0;
  logic wall_on_right_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] move_o;
  logic at_goal_o;
  logic [3:0] pos_x_o;
  logic [3:0] pos_y_o;
  logic [1:0] heading_o;
  logic reflooded_o;
  logic stack_overflow_o;

  always #6 clk_i = ~clk_i;

  maze_flood_fill_navigator_top u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_search_mode_i,
    .in_valid_i, .in_ready_o, .wall_ahead_i, .wall_on_left_i, .wall_on_right_i,
    .out_valid_o, .out_ready_i, .move_o, .at_goal_o, .pos_x_o, .pos_y_o, .heading_o,
    .reflooded_o, .stack_overflow_o
  );

  // ---------------------------------------------------------------------------
  // navigator mirror: maze memory, both cost maps, robot pose, reflood stack
  // ---------------------------------------------------------------------------
  logic [3:0] maze_walls[256];
  logic       maze_known[256];
  logic [7:0] centre_map[256];
  logic [7:0] home_map[256];
  logic [8:0] arrival_cell[256];
  logic [7:0] flood_stack[StackCells];
  int unsigned flood_sp;
  int unsigned bot_x, bot_y, bot_hd;
  logic seek_home;
  logic push_dropped;

  nav_result_t expected_q[$];
  logic run_failed = 1'b0;

  function automatic int unsigned cell_of(int unsigned x, int unsigned y);
    return ((x & 15) << 4) | (y & 15);
  endfunction

  function automatic int unsigned map_cost(int unsigned idx);
    return seek_home ? home_map[idx] : centre_map[idx];
  endfunction

  function automatic void map_write(int unsigned idx, int unsigned v);
    if (seek_home) home_map[idx] = 8'(v);
    else centre_map[idx] = 8'(v);
  endfunction

  function automatic bit goal_cell(int unsigned x, int unsigned y);
    if (seek_home) return x == 0 && y == 0;
    return (x == Side / 2 - 1 || x == Side / 2) && (y == Side / 2 - 1 || y == Side / 2);
  endfunction

  // neighbour in absolute direction, 0 when it falls off the grid
  function automatic bit neighbour(int unsigned x, int unsigned y, int unsigned d,
                                   output int unsigned nx, output int unsigned ny);
    nx = x;
    ny = y;
    case (dir_e'(d & 3))
      DIR_N: begin if (y + 1 >= Side) return 0; ny = y + 1; end
      DIR_E: begin if (x + 1 >= Side) return 0; nx = x + 1; end
      DIR_S: begin if (y == 0) return 0; ny = y - 1; end
      default: begin if (x == 0) return 0; nx = x - 1; end
    endcase
    return 1;
  endfunction

  function automatic int unsigned turn_of(int unsigned k);
    return (k == 0) ? 0 : (k == 1) ? 3 : 1;
  endfunction

  // cheapest open neighbour, front, left, right, then back
  function automatic int unsigned pick_move(logic [2:0] blk, output int unsigned best);
    int unsigned m, dir, nx, ny, k;
    logic [8:0] from;
    m = 2 * Side;
    dir = MOVE_NONE;
    for (k = 0; k < 3; k++) begin
      if (blk[k]) continue;
      if (!neighbour(bot_x, bot_y, bot_hd + turn_of(k), nx, ny)) continue;
      if (map_cost(cell_of(nx, ny)) < m) begin
        m = map_cost(cell_of(nx, ny));
        dir = k;
      end
    end
    from = arrival_cell[cell_of(bot_x, bot_y)];
    if (from[8] && map_cost(from[7:0]) < m) begin
      m = map_cost(from[7:0]);
      dir = MOVE_BACK;
    end
    best = m;
    return dir;
  endfunction

  function automatic void stack_push(int unsigned idx);
    if (flood_sp >= StackCells) begin
      push_dropped = 1'b1;
      return;
    end
    flood_stack[flood_sp] = 8'(idx);
    flood_sp++;
  endfunction

  function automatic int unsigned push_order(bit known, int unsigned j);
    if (known) return (j == 0) ? DIR_N : (j == 1) ? DIR_S : (j == 2) ? DIR_W : DIR_E;
    return (j == 0) ? DIR_E : (j == 1) ? DIR_W : (j == 2) ? DIR_N : DIR_S;
  endfunction

  // stack driven cost repair, unexplored cells count as open on all sides
  function automatic void repair_costs();
    int unsigned budget, idx, cx, cy, d, m, nv, nx, ny;
    bit open[4];
    budget = PopLimit;
    flood_sp = 0;
    stack_push(cell_of(bot_x, bot_y));
    while (flood_sp > 0) begin
      if (budget == 0) begin
        flood_sp = 0;
        break;
      end
      budget--;
      flood_sp--;
      idx = flood_stack[flood_sp];
      cx = idx >> 4;
      cy = idx & 15;
      if (goal_cell(cx, cy)) continue;
      m = 2 * Side;
      for (d = 0; d < 4; d++) begin
        open[d] = neighbour(cx, cy, d, nx, ny) && (!maze_known[idx] || !maze_walls[idx][d]);
        if (open[d] && map_cost(cell_of(nx, ny)) < m) m = map_cost(cell_of(nx, ny));
      end
      nv = (m + 1 > 255) ? 255 : m + 1;
      if (map_cost(idx) == nv) continue;
      map_write(idx, nv);
      for (d = 0; d < 4; d++) begin
        if (open[push_order(maze_known[idx], d)] &&
            neighbour(cx, cy, push_order(maze_known[idx], d), nx, ny))
          stack_push(cell_of(nx, ny));
      end
    end
  endfunction

  function automatic void maze_reset();
    int unsigned x, y, dx, dy, c;
    c = Side / 2;
    for (x = 0; x < Side; x++) begin
      for (y = 0; y < Side; y++) begin
        dx = (x < c) ? (c - 1 - x) : (x - c);
        dy = (y < c) ? (c - 1 - y) : (y - c);
        centre_map[cell_of(x, y)] = 8'(dx + dy);
        home_map[cell_of(x, y)] = 8'(x + y);
        maze_walls[cell_of(x, y)] = '0;
        maze_known[cell_of(x, y)] = 1'b0;
        arrival_cell[cell_of(x, y)] = '0;
      end
    end
    maze_walls[cell_of(0, 0)] = 4'b0100;
    bot_x = 0;
    bot_y = 0;
    bot_hd = DIR_N;
    flood_sp = 0;
    seek_home = 1'b0;
  endfunction

  function automatic nav_result_t navigate(logic [2:0] blk);
    nav_result_t r;
    int unsigned here, dir, best, k, d, nx, ny;
    logic [3:0] w;
    bit goal, flooded;
    here = cell_of(bot_x, bot_y);
    dir = MOVE_NONE;
    goal = 0;
    flooded = 0;
    push_dropped = 1'b0;
    if (!maze_known[here]) begin
      w = maze_walls[here];
      maze_known[here] = 1'b1;
      for (k = 0; k < 3; k++) begin
        d = (bot_hd + turn_of(k)) & 3;
        w[d] = blk[k];
      end
      maze_walls[here] = w;
    end
    if (goal_cell(bot_x, bot_y)) begin
      goal = 1;
    end else begin
      dir = pick_move(blk, best);
      if (map_cost(here) != best + 1) begin
        repair_costs();
        flooded = 1;
        dir = pick_move(blk, best);
      end
      if (dir != MOVE_NONE) begin
        if (dir == MOVE_LEFT) bot_hd = (bot_hd + 3) & 3;
        else if (dir == MOVE_RIGHT) bot_hd = (bot_hd + 1) & 3;
        else if (dir == MOVE_BACK) bot_hd = (bot_hd + 2) & 3;
        if (neighbour(bot_x, bot_y, bot_hd, nx, ny)) begin
          bot_x = nx;
          bot_y = ny;
          arrival_cell[cell_of(nx, ny)] = {1'b1, 8'(here)};
        end
      end
    end
    r.move = 3'(dir);
    r.at_goal = goal;
    r.pos_x = 4'(bot_x);
    r.pos_y = 4'(bot_y);
    r.heading = 2'(bot_hd);
    r.reflooded = flooded;
    r.stack_overflow = push_dropped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall, one long hold-off on request
  // ---------------------------------------------------------------------------
  int unsigned stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready_i <= 1'b0;
      hold_left <= HoldCycles;
      hold_taken <= 1'b1;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // scoreboard, each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    nav_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        run_failed <= 1'b1;
      end else begin
        exp_r = expected_q.pop_front();
        if (move_o !== exp_r.move) begin
          $error("move: expected %0d, got %0d", exp_r.move, move_o);
          run_failed <= 1'b1;
        end
        if (at_goal_o !== exp_r.at_goal) begin
          $error("at_goal: expected %0d, got %0d", exp_r.at_goal, at_goal_o);
          run_failed <= 1'b1;
        end
        if (pos_x_o !== exp_r.pos_x) begin
          $error("pos_x: expected %0d, got %0d", exp_r.pos_x, pos_x_o);
          run_failed <= 1'b1;
        end
        if (pos_y_o !== exp_r.pos_y) begin
          $error("pos_y: expected %0d, got %0d", exp_r.pos_y, pos_y_o);
          run_failed <= 1'b1;
        end
        if (heading_o !== exp_r.heading) begin
          $error("heading: expected %0d, got %0d", exp_r.heading, heading_o);
          run_failed <= 1'b1;
        end
        if (reflooded_o !== exp_r.reflooded) begin
          $error("reflooded: expected %0d, got %0d", exp_r.reflooded, reflooded_o);
          run_failed <= 1'b1;
        end
        if (stack_overflow_o !== exp_r.stack_overflow) begin
          $error("stack_overflow: expected %0d, got %0d", exp_r.stack_overflow,
                 stack_overflow_o);
          run_failed <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transfer, covers the clearing pass too
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WdLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sense side
  // ---------------------------------------------------------------------------
  int unsigned idle_pct = 0;

  task automatic send_arrival(logic [2:0] blk, bit typed, nav_result_t want);
    nav_result_t got;
    int unsigned gap;
    in_valid_i <= 1'b1;
    wall_ahead_i <= blk[0];
    wall_on_left_i <= blk[1];
    wall_on_right_i <= blk[2];
    do @(posedge clk_i); while (!in_ready_o);
    got = navigate(blk);
    expected_q.insert(expected_q.size(), typed ? want : got);
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until no result is outstanding, then write search_mode
  task automatic set_mode(logic m);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_search_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seek_home = m;
  endtask

  function automatic logic [2:0] random_walls();
    logic [2:0] b;
    for (int k = 0; k < 3; k++) b[k] = ($urandom_range(0, 99) < 30);
    return b;
  endfunction

  sense_row_t directed[$];

  function automatic void add_row(sense_row_t row);
    directed.insert(directed.size(), row);
  endfunction

  initial begin
    nav_result_t none_r;
    logic [2:0] blk;
    logic mode_now;
    none_r = '0;
    maze_reset();
    // goal at once in return mode, then the first plain forward step
    add_row({1'b1, 3'b000, 1'b1, {3'(MOVE_NONE), 1'b1, 4'd0, 4'd0, 2'(DIR_N), 2'b00}});
    add_row({1'b0, 3'b000, 1'b1, {3'(MOVE_FWD), 1'b0, 4'd0, 4'd1, 2'(DIR_N), 2'b00}});
    // every sensor combination, boxed in cells, corners and a turn-around
    for (int k = 0; k < 8; k++) add_row({1'b0, 3'(k), 1'b0, none_r});
    for (int k = 0; k < 5; k++) add_row({1'b0, 3'b111, 1'b0, none_r});
    for (int k = 0; k < 4; k++) add_row({1'b1, 3'(k), 1'b0, none_r});
    for (int k = 0; k < 4; k++) add_row({1'b0, 3'b011, 1'b0, none_r});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    mode_now = 1'b0;
    foreach (directed[i]) begin
      if (directed[i].mode != mode_now || i == 0) begin
        set_mode(directed[i].mode);
        mode_now = directed[i].mode;
      end
      send_arrival({directed[i].wall_r, directed[i].wall_l, directed[i].wall_a},
                   directed[i].typed, directed[i].want);
    end

    // random walks: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0]);
      idle_pct = (ph == 1) ? 85 : (ph == 3) ? 23 : 0;
      stall_pct = (ph == 2) ? 85 : (ph == 3) ? 23 : 0;
      if (ph == 0) hold_req <= 1'b1;
      for (int n = 0; n < RandPerPh; n++) begin
        blk = random_walls();
        send_arrival(blk, 1'b0, none_r);
      end
    end
    set_mode(1'b0);
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!run_failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/mffn_pkg.sv
rtl/maze_flood_fill_navigator_top.sv
tb/sv/maze_flood_fill_navigator_top_test.sv
